// ===== hdl/srm_pkg.sv =====
// Shared types, codes and line-sequencing helpers for the SPI register access master.
package srm_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_WDATA = 3'd2,
    PH_RDATA = 3'd3,
    PH_GAP   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_SET   = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_SET   = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd16;
  localparam logic [7:0] ADDR_MASK         = 8'h7E;
  localparam logic [7:0] READ_FLAG         = 8'h80;
  localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

  typedef struct packed {
    logic [2:0] command;
    logic [5:0] reg_address;
    logic [7:0] data_value;
    logic       miso;
  } item_t;

  typedef struct packed {
    logic       cs_n;
    logic       sclk;
    logic       mosi;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       rejected;
  } result_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] bit_index;
    logic       half_step;
    logic [7:0] tick_count;
    logic [7:0] tx_shift;
    logic [7:0] rx_shift;
    logic [7:0] pending_mask;
    kind_t      pending_kind;
    logic [5:0] saved_address;
    logic       select_line;
    logic       clock_line;
    logic       data_line;
    logic [7:0] last_read;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase: PH_IDLE, bit_index: 4'd0, half_step: 1'b0, tick_count: 8'd0,
    tx_shift: 8'd0, rx_shift: 8'd0, pending_mask: 8'd0, pending_kind: KIND_READ,
    saved_address: 6'd0, select_line: 1'b1, clock_line: 1'b1, data_line: 1'b0,
    last_read: 8'd0
  };

  // Drive clock and data for the current half bit.
  function automatic state_t set_lines(state_t s);
    state_t r;
    r = s;
    if (s.phase == PH_RDATA) begin
      r.clock_line = ~s.half_step;
    end else if (s.phase == PH_ADDR || s.phase == PH_WDATA) begin
      if (!s.half_step) begin
        r.data_line  = s.tx_shift[7];
        r.clock_line = 1'b0;
      end else begin
        r.clock_line = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic state_t start_byte(state_t s, phase_t ph, logic [7:0] byte_val);
    state_t r;
    r = s;
    r.phase    = ph;
    r.tx_shift = byte_val;
    if (ph == PH_RDATA) begin
      r.rx_shift = 8'd0;
    end
    r.bit_index  = 4'd0;
    r.half_step  = 1'b0;
    r.tick_count = 8'd0;
    return set_lines(r);
  endfunction

  function automatic logic [7:0] address_byte(state_t s);
    logic [7:0] a;
    a = {1'b0, s.saved_address, 1'b0} & ADDR_MASK;
    if (s.pending_kind != KIND_WRITE) begin
      a = a | READ_FLAG;
    end
    return a;
  endfunction

endpackage

// ===== hdl/srm_if.sv =====
// Handshake channel interfaces for command words, result words and configuration writes.
interface srm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [5:0] reg_address;
  logic [7:0] data_value;
  logic       miso;
  modport source (output valid, command, reg_address, data_value, miso, input ready);
  modport sink   (input valid, command, reg_address, data_value, miso, output ready);
endinterface

interface srm_out_if;
  logic       valid;
  logic       ready;
  logic       cs_n;
  logic       sclk;
  logic       mosi;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       rejected;
  modport source (output valid, cs_n, sclk, mosi, busy_res, done_res, read_data, rejected,
                  input ready);
  modport sink   (input valid, cs_n, sclk, mosi, busy_res, done_res, read_data, rejected,
                  output ready);
endinterface

interface srm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] half_period_ticks;
  modport source (output valid, half_period_ticks, input ready);
  modport sink   (input valid, half_period_ticks, output ready);
endinterface

// ===== hdl/srm_step.sv =====
// Next-state and result logic for one word of the SPI transaction sequencer.
module srm_step
  import srm_pkg::*;
(
  input  state_t     st,
  input  item_t      item,
  input  logic [7:0] half_period,
  output state_t     st_nxt,
  output result_t    res
);

  state_t     n;
  logic       busy;
  logic       is_cmd;
  logic       done;
  logic       rej;
  logic [7:0] period;
  logic [8:0] count;
  kind_t      kind;

  always_comb begin
    unique case (item.command)
      CMD_READ:  kind = KIND_READ;
      CMD_WRITE: kind = KIND_WRITE;
      CMD_SET:   kind = KIND_SET;
      default:   kind = KIND_CLEAR;
    endcase
  end

  always_comb begin
    n      = st;
    busy   = (st.phase != PH_IDLE);
    is_cmd = (item.command >= CMD_READ) && (item.command <= CMD_CLEAR);
    done   = 1'b0;
    rej    = 1'b0;
    // A zero half period behaves like one tick.
    period = (half_period == 8'd0) ? 8'd1 : half_period;
    count  = {1'b0, st.tick_count} + 9'd1;

    if (is_cmd && !busy) begin
      n.saved_address = item.reg_address;
      n.pending_mask  = item.data_value;
      n.pending_kind  = kind;
      n.select_line   = 1'b0;
      n = start_byte(n, PH_ADDR, address_byte(n));
    end else begin
      rej = is_cmd;
      if (busy) begin
        if (count < {1'b0, period}) begin
          n.tick_count = count[7:0];
        end else begin
          n.tick_count = 8'd0;
          if (st.phase == PH_GAP) begin
            n.select_line = 1'b0;
            n = start_byte(n, PH_ADDR, address_byte(n));
          end else if (!st.half_step) begin
            n.half_step = 1'b1;
            n = set_lines(n);
          end else begin
            if (st.phase == PH_RDATA) begin
              n.rx_shift = {st.rx_shift[6:0], item.miso};
            end else begin
              n.tx_shift = {st.tx_shift[6:0], 1'b0};
            end
            n.half_step = 1'b0;
            n.bit_index = st.bit_index + 4'd1;
            if (n.bit_index < BITS_PER_BYTE) begin
              n = set_lines(n);
            end else begin
              n.bit_index = 4'd0;
              if (st.phase == PH_ADDR) begin
                if (st.pending_kind == KIND_WRITE) begin
                  n = start_byte(n, PH_WDATA, st.pending_mask);
                end else begin
                  n = start_byte(n, PH_RDATA, 8'd0);
                end
              end else begin
                n.select_line = 1'b1;
                if (st.phase == PH_RDATA) begin
                  n.last_read = n.rx_shift;
                  // Read-modify-write goes on to a write of the merged byte.
                  if (st.pending_kind == KIND_SET) begin
                    n.pending_mask = n.rx_shift | st.pending_mask;
                    n.pending_kind = KIND_WRITE;
                    n.phase        = PH_GAP;
                  end else if (st.pending_kind == KIND_CLEAR) begin
                    n.pending_mask = n.rx_shift & ~st.pending_mask;
                    n.pending_kind = KIND_WRITE;
                    n.phase        = PH_GAP;
                  end else begin
                    n.phase = PH_IDLE;
                    done    = 1'b1;
                  end
                end else begin
                  n.phase = PH_IDLE;
                  done    = 1'b1;
                end
              end
            end
          end
        end
      end
    end
  end

  assign st_nxt        = n;
  assign res.cs_n      = n.select_line;
  assign res.sclk      = n.clock_line;
  assign res.mosi      = n.data_line;
  assign res.busy_res  = (n.phase != PH_IDLE);
  assign res.done_res  = done;
  assign res.read_data = n.last_read;
  assign res.rejected  = rej;

endmodule

// ===== hdl/spi_register_access_master.sv =====
// Top level of the SPI register access master: input word register, sequencer state, result register.
//
//   channel  | dir | payload                                             | accepted when
//   in_ch    | in  | command, reg_address, data_value, miso              | valid & ready
//   out_ch   | out | cs_n, sclk, mosi, busy_res, done_res, read_data,    | valid & ready
//            |     | rejected                                            |
//   cfg_ch   | in  | half_period_ticks                                   | valid & ready
//
// Each word passes from acceptance through the input register, then through the sequencer logic
// into the result register. One word is accepted per cycle while the result is not stalled.
// A stalled result holds the sequencer and the input register; the input register frees up
// the same cycle the result is taken. cfg_ch is always ready.
// Reset (rst_n low, synchronous) idles the sequencer, deselects the slave and sets the half
// period to 16 ticks.
module spi_register_access_master
  import srm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  srm_in_if.sink    in_ch,
  srm_out_if.source out_ch,
  srm_cfg_if.sink   cfg_ch
);

  logic       in_valid_r;
  item_t      in_item_r;
  logic       out_valid_r;
  result_t    out_res_r;
  state_t     st_r;
  state_t     st_nxt;
  result_t    res_nxt;
  logic [7:0] half_period_r;
  logic       adv;
  logic       in_take;

  assign adv     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !in_valid_r || adv;
  assign cfg_ch.ready = 1'b1;

  srm_step u_step (
    .st          (st_r),
    .item        (in_item_r),
    .half_period (half_period_r),
    .st_nxt      (st_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      st_r          <= STATE_RESET;
      half_period_r <= HALF_PERIOD_RESET;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        half_period_r <= cfg_ch.half_period_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.command     <= in_ch.command;
      in_item_r.reg_address <= in_ch.reg_address;
      in_item_r.data_value  <= in_ch.data_value;
      in_item_r.miso        <= in_ch.miso;
    end
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.cs_n      = out_res_r.cs_n;
  assign out_ch.sclk      = out_res_r.sclk;
  assign out_ch.mosi      = out_res_r.mosi;
  assign out_ch.busy_res  = out_res_r.busy_res;
  assign out_ch.done_res  = out_res_r.done_res;
  assign out_ch.read_data = out_res_r.read_data;
  assign out_ch.rejected  = out_res_r.rejected;

`ifndef SYNTHESIS
  // The slave is never selected while the sequencer is idle.
  a_idle_deselected: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_IDLE |-> st_r.select_line)
    else $error("slave selected while idle");

  // A completing word always leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res && out_ch.cs_n)
    else $error("done reported while still busy");

  // The sequencer only moves when a word was held in the input register.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(st_r))
    else $error("sequencer state changed without a word");
`endif

endmodule

// ===== test/srm_result_check.sv =====
// Result checker for the SPI register access master: predicts every result word and compares.
module srm_result_check
  import srm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  srm_in_if    in_ch,
  srm_out_if   out_ch,
  srm_cfg_if   cfg_ch,
  output int   pending_words,
  output int   fail_count,
  output int   checked_words,
  output int   done_words,
  output int   rejected_words
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted sequencer state and line levels.
  phase_t     stage;
  kind_t      op_kind;
  logic [3:0] bit_no;
  logic       upper_half;
  logic [7:0] tick_no;
  logic [7:0] tx_byte;
  logic [7:0] rx_byte;
  logic [7:0] operand;
  logic [7:0] last_byte;
  logic [7:0] half_ticks;
  logic [5:0] reg_addr;
  logic       cs_line;
  logic       sclk_line;
  logic       mosi_line;

  result_t expected_lines[$];

  function automatic void drive_lines();
    case (stage)
      PH_RDATA: sclk_line = ~upper_half;
      PH_ADDR, PH_WDATA: begin
        if (!upper_half) begin
          mosi_line = tx_byte[7];
          sclk_line = 1'b0;
        end else begin
          sclk_line = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void load_byte(phase_t next_stage, logic [7:0] value);
    stage = next_stage;
    tx_byte = value;
    if (next_stage == PH_RDATA) rx_byte = 8'd0;
    bit_no = 4'd0;
    upper_half = 1'b0;
    tick_no = 8'd0;
    drive_lines();
  endfunction

  // Everything but a plain write goes out with the read flag in the top bit.
  function automatic logic [7:0] header_byte();
    return {op_kind != KIND_WRITE, reg_addr, 1'b0};
  endfunction

  // One tick of a running sequence; returns 1 when the whole command completes.
  function automatic logic advance_half(logic miso);
    int unsigned span;
    int unsigned count;
    span = (half_ticks == 8'd0) ? 1 : half_ticks;
    count = tick_no + 1;
    if (count < span) begin
      tick_no = count[7:0];
      return 1'b0;
    end
    tick_no = 8'd0;
    if (stage == PH_GAP) begin
      cs_line = 1'b0;
      load_byte(PH_ADDR, header_byte());
      return 1'b0;
    end
    if (!upper_half) begin
      upper_half = 1'b1;
      drive_lines();
      return 1'b0;
    end
    if (stage == PH_RDATA) rx_byte = {rx_byte[6:0], miso};
    else tx_byte = tx_byte << 1;
    upper_half = 1'b0;
    bit_no = bit_no + 4'd1;
    if (bit_no < BITS_PER_BYTE) begin
      drive_lines();
      return 1'b0;
    end
    bit_no = 4'd0;
    if (stage == PH_ADDR) begin
      if (op_kind == KIND_WRITE) load_byte(PH_WDATA, operand);
      else load_byte(PH_RDATA, 8'd0);
      return 1'b0;
    end
    cs_line = 1'b1;
    if (stage == PH_RDATA) begin
      last_byte = rx_byte;
      if (op_kind == KIND_SET) begin
        operand = rx_byte | operand;
      end else if (op_kind == KIND_CLEAR) begin
        operand = rx_byte & ~operand;
      end else begin
        stage = PH_IDLE;
        return 1'b1;
      end
      // Read-modify-write: chip select stays high for one half period first.
      op_kind = KIND_WRITE;
      stage = PH_GAP;
      return 1'b0;
    end
    stage = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic result_t predict_lines(logic [2:0] cmd, logic [5:0] addr,
                                            logic [7:0] value, logic miso);
    result_t r;
    logic    is_cmd;
    logic    was_busy;
    logic    done;
    is_cmd = (cmd >= CMD_READ) && (cmd <= CMD_CLEAR);
    was_busy = (stage != PH_IDLE);
    done = 1'b0;
    r.rejected = 1'b0;
    if (is_cmd && !was_busy) begin
      reg_addr = addr;
      operand = value;
      case (cmd)
        CMD_READ:  op_kind = KIND_READ;
        CMD_WRITE: op_kind = KIND_WRITE;
        CMD_SET:   op_kind = KIND_SET;
        default:   op_kind = KIND_CLEAR;
      endcase
      cs_line = 1'b0;
      load_byte(PH_ADDR, header_byte());
    end else begin
      r.rejected = is_cmd;
      if (was_busy) done = advance_half(miso);
    end
    r.cs_n = cs_line;
    r.sclk = sclk_line;
    r.mosi = mosi_line;
    r.busy_res = (stage != PH_IDLE);
    r.done_res = done;
    r.read_data = last_byte;
    return r;
  endfunction

  function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      stage = PH_IDLE;
      op_kind = KIND_READ;
      bit_no = 4'd0;
      upper_half = 1'b0;
      tick_no = 8'd0;
      tx_byte = 8'd0;
      rx_byte = 8'd0;
      operand = 8'd0;
      last_byte = 8'd0;
      half_ticks = HALF_PERIOD_RESET;
      reg_addr = 6'd0;
      cs_line = 1'b1;
      sclk_line = 1'b1;
      mosi_line = 1'b0;
      expected_lines.delete();
      fail_count = 0;
      checked_words = 0;
      done_words = 0;
      rejected_words = 0;
    end else begin
      // Results pass through the input and result registers after their inputs, so pop before pushing.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_lines.size() == 0) begin
          $error("result word arrived with no word pending");
          fail_count++;
        end else begin
          want = expected_lines.pop_front();
          compare_field("cs_n", 8'(want.cs_n), 8'(out_ch.cs_n));
          compare_field("sclk", 8'(want.sclk), 8'(out_ch.sclk));
          compare_field("mosi", 8'(want.mosi), 8'(out_ch.mosi));
          compare_field("busy_res", 8'(want.busy_res), 8'(out_ch.busy_res));
          compare_field("done_res", 8'(want.done_res), 8'(out_ch.done_res));
          compare_field("read_data", want.read_data, out_ch.read_data);
          compare_field("rejected", 8'(want.rejected), 8'(out_ch.rejected));
          checked_words++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) half_ticks = cfg_ch.half_period_ticks;
      if (in_ch.valid && in_ch.ready) begin
        want = predict_lines(in_ch.command, in_ch.reg_address, in_ch.data_value,
                             in_ch.miso);
        if (want.done_res) done_words++;
        if (want.rejected) rejected_words++;
        expected_lines.push_back(want);
      end
    end
    pending_words <= expected_lines.size();
  end

endmodule

// ===== test/spi_register_access_master_test.sv =====
// Stimulus, clock, reset and verdict for the SPI register access master.
module spi_register_access_master_test;
  timeunit 1ns;
  timeprecision 1ps;
  import srm_pkg::*;

  localparam logic [2:0] CMD_LAST_CODE = 3'd7;
  localparam int STALL_LIMIT = 1000;

  typedef enum logic [1:0] {MISO_RANDOM, MISO_ZEROS, MISO_ONES} miso_mode_t;

  logic clk;
  logic rst_n;

  srm_in_if  in_ch();
  srm_out_if out_ch();
  srm_cfg_if cfg_ch();

  int pending_words;
  int fail_count;
  int checked_words;
  int done_words;
  int rejected_words;

  int         sent_words;
  int         stall_cycles;
  bit         steady;
  miso_mode_t miso_mode;
  logic [7:0] half_now;

  spi_register_access_master dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  srm_result_check result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .pending_words  (pending_words),
    .fail_count     (fail_count),
    .checked_words  (checked_words),
    .done_words     (done_words),
    .rejected_words (rejected_words)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Ticks from a command word to its completion at the current half period.
  function automatic int transaction_ticks(input logic [2:0] cmd);
    int span;
    int one_pass;
    span = (half_now == 8'd0) ? 1 : half_now;
    one_pass = 4 * BITS_PER_BYTE * span;
    if (cmd == CMD_SET || cmd == CMD_CLEAR) return 2 * one_pass + span;
    return one_pass;
  endfunction

  task automatic send_word(input logic [2:0] cmd, input logic [5:0] addr,
                           input logic [7:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.reg_address <= addr;
    in_ch.data_value <= value;
    case (miso_mode)
      MISO_ZEROS: in_ch.miso <= 1'b0;
      MISO_ONES:  in_ch.miso <= 1'b1;
      default:    in_ch.miso <= 1'($urandom);
    endcase
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_words++;
  endtask

  // A tick word, now and then replaced by a stray command or an undefined code.
  task automatic send_tick(input bit may_start);
    logic [2:0] code;
    code = CMD_TICK;
    if ($urandom_range(0, 99) < 4) begin
      if (may_start) code = 3'($urandom_range(CMD_READ, CMD_LAST_CODE));
      else code = 3'($urandom_range(CMD_CLEAR + 1, CMD_LAST_CODE));
    end
    send_word(code, 6'($urandom), 8'($urandom));
  endtask

  task automatic run_transaction(input logic [2:0] cmd, input logic [5:0] addr,
                                 input logic [7:0] value, input bit cut_short);
    int n;
    n = transaction_ticks(cmd);
    if (cut_short) n = $urandom_range(0, n - 1);
    send_word(cmd, addr, value);
    repeat (n) send_tick(1'b1);
    repeat ($urandom_range(0, 3)) send_tick(1'b0);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_half_period(input logic [7:0] value);
    wait_for_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.half_period_ticks <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    half_now = value;
  endtask

  task automatic random_block(input int budget);
    int         start;
    int         r;
    logic [5:0] addr;
    logic [7:0] value;
    start = sent_words;
    while (sent_words - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 10) addr = 6'd0;
      else if (r < 20) addr = 6'h3F;
      else addr = 6'($urandom);
      r = $urandom_range(0, 99);
      if (r < 10) value = 8'h00;
      else if (r < 20) value = 8'hFF;
      else value = 8'($urandom);
      run_transaction(3'($urandom_range(CMD_READ, CMD_CLEAR)), addr, value,
                      $urandom_range(0, 99) < 8);
      if ($urandom_range(0, 99) < 3) wait_for_results();
    end
  endtask

  initial begin : result_ready
    int hold;
    int r;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 70) hold = $urandom_range(1, 4);
      else if (r < 95) hold = $urandom_range(5, 30);
      else hold = $urandom_range(50, 200);
      repeat (hold) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("FAIL spi_register_access_master");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int code;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_TICK;
    in_ch.reg_address = 6'd0;
    in_ch.data_value = 8'd0;
    in_ch.miso = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.half_period_ticks = HALF_PERIOD_RESET;
    sent_words = 0;
    steady = 1'b0;
    miso_mode = MISO_ONES;
    half_now = HALF_PERIOD_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset half period with slave data all ones: every other code arrives while the read
    // runs, then the half period drops to one tick two half bits into the address byte.
    send_word(CMD_READ, 6'd0, 8'd0);
    for (code = CMD_WRITE; code <= CMD_LAST_CODE; code++) begin
      send_word(code[2:0], 6'h3F, 8'hFF);
    end
    repeat (2 * HALF_PERIOD_RESET - 6) send_tick(1'b0);
    set_half_period(8'd1);
    repeat (transaction_ticks(CMD_READ)) send_tick(1'b0);

    miso_mode = MISO_ZEROS;
    run_transaction(CMD_READ, 6'h3F, 8'h00, 1'b0);
    miso_mode = MISO_RANDOM;
    run_transaction(CMD_WRITE, 6'h3F, 8'hFF, 1'b0);
    run_transaction(CMD_WRITE, 6'd0, 8'h00, 1'b0);
    run_transaction(CMD_SET, 6'h15, 8'hFF, 1'b0);
    run_transaction(CMD_CLEAR, 6'h2A, 8'hFF, 1'b0);
    // Undefined codes and ticks while idle only pass time.
    send_word(CMD_TICK, 6'h3F, 8'hFF);
    for (code = CMD_CLEAR + 1; code <= CMD_LAST_CODE; code++) begin
      send_word(code[2:0], 6'h2A, 8'h55);
    end

    // A zero half period behaves like one tick.
    set_half_period(8'd0);
    run_transaction(CMD_WRITE, 6'h2A, 8'hA5, 1'b0);

    set_half_period(8'd1);
    random_block(100);
    steady = 1'b1;
    set_half_period(8'd2);
    random_block(60);
    steady = 1'b0;

    wait_for_results();
    repeat (8) @(posedge clk);
    $display("Read, write, set-bits and clear-bits commands ran at half periods 0, 1, 2 and 16,");
    $display("with %0d result words checked, %0d commands completed and %0d rejected.",
             checked_words, done_words, rejected_words);
    if (fail_count == 0) $display("PASS spi_register_access_master");
    else $display("FAIL spi_register_access_master");
    $finish;
  end

endmodule

// ===== spi_register_access_master.f =====
hdl/srm_pkg.sv
hdl/srm_if.sv
hdl/srm_step.sv
hdl/spi_register_access_master.sv
test/srm_result_check.sv
test/spi_register_access_master_test.sv
